FILE: sv/obbcd_pkg.sv
// Shared types and constants for the oriented box collision/distance block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package obbcd_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int SQ_W        = 85;
	localparam int RAD_W       = 66;
	localparam int ROOT_W      = 33;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        hx;
		logic [30:0]        hy;
		logic signed [15:0] c;
		logic signed [15:0] s;
	} box_t;

	typedef struct packed {
		box_t a;
		box_t b;
		logic ovl;
	} job_t;

	typedef struct packed {
		logic vld;
		logic ovl;
	} ctl_t;

	typedef struct packed {
		logic ovl;
		logic sat;
	} tag_t;

endpackage

FILE: sv/oriented_box_collision_distance.sv
// Oriented box collision test and clearance distance, top level.
// done pulses once per transaction; one transaction per cycle while busy is low.
// Throughput is set by the fully pipelined separation test, corner distance and root.
// The result receiver cannot stall; busy rises only if the queue could overflow.
// Reset (arst_n low) clears all valid bits and queue pointers; no clearing pass.
// Depends on obbcd_pkg, obbcd_front, obbcd_queue, obbcd_back.
`timescale 1ns / 1ps

module oriented_box_collision_distance #(
	parameter int QDEPTH = obbcd_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] a_center_x,
	input  logic signed [31:0] a_center_y,
	input  logic [30:0]        a_half_width,
	input  logic [30:0]        a_half_height,
	input  logic signed [15:0] a_cosine,
	input  logic signed [15:0] a_sine,
	input  logic signed [31:0] b_center_x,
	input  logic signed [31:0] b_center_y,
	input  logic [30:0]        b_half_width,
	input  logic [30:0]        b_half_height,
	input  logic signed [15:0] b_cosine,
	input  logic signed [15:0] b_sine,
	output logic               done,
	output logic               overlapping,
	output logic [32:0]        gap_distance
);
	import obbcd_pkg::*;

	localparam int CW = $clog2(QDEPTH + 1);
	localparam int OW = ((CW > 3) ? CW : 3) + 1;

	box_t          a_box, b_box;
	logic          front_vld;
	job_t          front_job;
	logic [2:0]    inflight;
	job_t          head_job;
	logic          head_vld;
	logic [CW-1:0] q_count;
	logic [OW-1:0] occ;

	assign a_box = '{cx: a_center_x, cy: a_center_y, hx: a_half_width, hy: a_half_height,
		c: a_cosine, s: a_sine};
	assign b_box = '{cx: b_center_x, cy: b_center_y, hx: b_half_width, hy: b_half_height,
		c: b_cosine, s: b_sine};

	assign occ  = OW'(q_count) + OW'(inflight);
	assign busy = occ >= OW'(QDEPTH);

	obbcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start && !busy),
		.a_in     (a_box),
		.b_in     (b_box),
		.out_vld  (front_vld),
		.out_job  (front_job),
		.inflight (inflight)
	);

	obbcd_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_vld),
		.din      (front_job),
		.pop      (head_vld),
		.dout     (head_job),
		.head_vld (head_vld),
		.count    (q_count)
	);

	obbcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (head_vld),
		.in_job       (head_job),
		.done         (done),
		.overlapping  (overlapping),
		.gap_distance (gap_distance)
	);

endmodule

FILE: sv/obbcd_front.sv
// Front part: registers each transaction and runs the four-axis separation test.
// Depends on obbcd_pkg. Five stages, one transaction per cycle.
`timescale 1ns / 1ps

module obbcd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  obbcd_pkg::box_t   a_in,
	input  obbcd_pkg::box_t   b_in,
	output logic              out_vld,
	output obbcd_pkg::job_t   out_job,
	output logic [2:0]        inflight
);
	import obbcd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	box_t a_s1, b_s1, a_s2, b_s2, a_s3, b_s3, a_s4, b_s4;
	job_t job_s5;

	logic signed [32:0] dx_s2, dy_s2;
	logic signed [16:0] ux_s2 [4];
	logic signed [16:0] uy_s2 [4];

	logic signed [50:0] dot_s3 [4];
	logic signed [33:0] aax_s3 [4];
	logic signed [33:0] aay_s3 [4];
	logic signed [33:0] bax_s3 [4];
	logic signed [33:0] bay_s3 [4];

	logic [50:0] gap_s4 [4];
	logic [62:0] rax_s4 [4];
	logic [62:0] ray_s4 [4];
	logic [62:0] rbx_s4 [4];
	logic [62:0] rby_s4 [4];

	logic signed [32:0] dx_c, dy_c;
	logic signed [16:0] ux_c [4];
	logic signed [16:0] uy_c [4];
	logic signed [50:0] dot_c [4];
	logic signed [33:0] aax_c [4];
	logic signed [33:0] aay_c [4];
	logic signed [33:0] bax_c [4];
	logic signed [33:0] bay_c [4];
	logic [50:0] gap_c [4];
	logic [62:0] rax_c [4];
	logic [62:0] ray_c [4];
	logic [62:0] rbx_c [4];
	logic [62:0] rby_c [4];
	logic [3:0]  sep_c;

	function automatic logic [31:0] mag34(input logic signed [33:0] v);
		logic signed [33:0] n;
		n = -v;
		return v[33] ? n[31:0] : v[31:0];
	endfunction

	// stage 1 -> 2: centre gap and the four test axes
	always_comb begin
		dx_c    = 33'($signed(b_s1.cx)) - 33'($signed(a_s1.cx));
		dy_c    = 33'($signed(b_s1.cy)) - 33'($signed(a_s1.cy));
		ux_c[0] = 17'($signed(a_s1.c));
		uy_c[0] = 17'($signed(a_s1.s));
		ux_c[1] = -17'($signed(a_s1.s));
		uy_c[1] = 17'($signed(a_s1.c));
		ux_c[2] = 17'($signed(b_s1.c));
		uy_c[2] = 17'($signed(b_s1.s));
		ux_c[3] = -17'($signed(b_s1.s));
		uy_c[3] = 17'($signed(b_s1.c));
	end

	// stage 2 -> 3: projections
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			dot_c[k] = 51'(dx_s2) * 51'(ux_s2[k]) + 51'(dy_s2) * 51'(uy_s2[k]);
			aax_c[k] = 34'($signed(a_s2.c)) * 34'(ux_s2[k])
				+ 34'($signed(a_s2.s)) * 34'(uy_s2[k]);
			aay_c[k] = 34'($signed(a_s2.c)) * 34'(uy_s2[k])
				- 34'($signed(a_s2.s)) * 34'(ux_s2[k]);
			bax_c[k] = 34'($signed(b_s2.c)) * 34'(ux_s2[k])
				+ 34'($signed(b_s2.s)) * 34'(uy_s2[k]);
			bay_c[k] = 34'($signed(b_s2.c)) * 34'(uy_s2[k])
				- 34'($signed(b_s2.s)) * 34'(ux_s2[k]);
		end
	end

	// stage 3 -> 4: magnitudes and projected radii
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			gap_c[k] = dot_s3[k][50] ? 51'(-dot_s3[k]) : 51'(dot_s3[k]);
			rax_c[k] = 63'(a_s3.hx) * 63'(mag34(aax_s3[k]));
			ray_c[k] = 63'(a_s3.hy) * 63'(mag34(aay_s3[k]));
			rbx_c[k] = 63'(b_s3.hx) * 63'(mag34(bax_s3[k]));
			rby_c[k] = 63'(b_s3.hy) * 63'(mag34(bay_s3[k]));
		end
	end

	// stage 4 -> 5: strict compare per axis
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sep_c[k] = {1'b0, gap_s4[k], 14'b0} >
				(66'(rax_s4[k]) + 66'(ray_s4[k]) + 66'(rbx_s4[k]) + 66'(rby_s4[k]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= a_in;
		b_s1  <= b_in;
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		dx_s2 <= dx_c;
		dy_s2 <= dy_c;
		ux_s2 <= ux_c;
		uy_s2 <= uy_c;
		a_s3  <= a_s2;
		b_s3  <= b_s2;
		dot_s3 <= dot_c;
		aax_s3 <= aax_c;
		aay_s3 <= aay_c;
		bax_s3 <= bax_c;
		bay_s3 <= bay_c;
		a_s4  <= a_s3;
		b_s4  <= b_s3;
		gap_s4 <= gap_c;
		rax_s4 <= rax_c;
		ray_s4 <= ray_c;
		rbx_s4 <= rbx_c;
		rby_s4 <= rby_c;
		job_s5.a   <= a_s4;
		job_s5.b   <= b_s4;
		job_s5.ovl <= ~|sep_c;
	end

	assign out_vld  = v_s5;
	assign out_job  = job_s5;
	assign inflight = {2'b0, v_s1} + {2'b0, v_s2} + {2'b0, v_s3} + {2'b0, v_s4}
		+ {2'b0, v_s5};

endmodule

FILE: sv/obbcd_queue.sv
// Short FIFO between the front and back parts.
// Depends on obbcd_pkg for the transaction type.
`timescale 1ns / 1ps

module obbcd_queue #(
	parameter int DEPTH = obbcd_pkg::QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  obbcd_pkg::job_t   din,
	input  logic              pop,
	output obbcd_pkg::job_t   dout,
	output logic              head_vld,
	output logic [CW-1:0]     count
);
	import obbcd_pkg::*;

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	assign dout     = mem_q[rd_ptr_q];
	assign head_vld = (count_q != '0);
	assign count    = count_q;

endmodule

FILE: sv/obbcd_sqrt.sv
// Pipelined floor square root, one root bit per stage, 33 stages.
// Depends on obbcd_pkg for widths and the sideband tag.
`timescale 1ns / 1ps

module obbcd_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  obbcd_pkg::tag_t               in_tag,
	input  logic [obbcd_pkg::RAD_W-1:0]   radicand,
	output logic                          out_vld,
	output obbcd_pkg::tag_t               out_tag,
	output logic [obbcd_pkg::ROOT_W-1:0]  root
);
	import obbcd_pkg::*;

	logic              vld_q  [ROOT_W+1];
	tag_t              tag_q  [ROOT_W+1];
	logic [35:0]       rem_q  [ROOT_W+1];
	logic [ROOT_W-1:0] root_q [ROOT_W+1];
	logic [RAD_W-1:0]  val_q  [ROOT_W+1];

	assign vld_q[0]  = in_vld;
	assign tag_q[0]  = in_tag;
	assign rem_q[0]  = '0;
	assign root_q[0] = '0;
	assign val_q[0]  = radicand;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic [35:0] rem_in, trial;
		logic        ge;

		assign rem_in = {rem_q[i][33:0], val_q[i][RAD_W-1:RAD_W-2]};
		assign trial  = {1'b0, root_q[i], 2'b01};
		assign ge     = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else begin
				vld_q[i+1] <= vld_q[i];
			end
		end

		always_ff @(posedge clk) begin
			tag_q[i+1]  <= tag_q[i];
			rem_q[i+1]  <= ge ? rem_in - trial : rem_in;
			root_q[i+1] <= {root_q[i][ROOT_W-2:0], ge};
			val_q[i+1]  <= {val_q[i][RAD_W-3:0], 2'b00};
		end
	end

	assign out_vld = vld_q[ROOT_W];
	assign out_tag = tag_q[ROOT_W];
	assign root    = root_q[ROOT_W];

endmodule

FILE: sv/obbcd_back.sv
// Back part: eight corners, point-to-box distances, minimum and square root.
// Depends on obbcd_pkg and obbcd_sqrt. Twelve stages plus the root pipeline.
`timescale 1ns / 1ps

module obbcd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  obbcd_pkg::job_t               in_job,
	output logic                          done,
	output logic                          overlapping,
	output logic [obbcd_pkg::ROOT_W-1:0]  gap_distance
);
	import obbcd_pkg::*;

	localparam logic [3:0] KX_POS = 4'b0011;
	localparam logic [3:0] KY_POS = 4'b1001;

	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	ctl_t ctl_s7, ctl_s8, ctl_s9, ctl_s10, ctl_s11, ctl_s12;
	job_t j_s1, j_s2, j_s3, j_s4, j_s5, j_s6;

	logic signed [46:0] p_s2 [2];
	logic signed [46:0] q_s2 [2];
	logic signed [46:0] r_s2 [2];
	logic signed [46:0] t_s2 [2];
	logic signed [48:0] rawx_s3 [8];
	logic signed [48:0] rawy_s3 [8];
	logic signed [35:0] wx_s4 [8];
	logic signed [35:0] wy_s4 [8];
	logic signed [36:0] rx_s5 [8];
	logic signed [36:0] ry_s5 [8];
	logic signed [53:0] lx_s6 [8];
	logic signed [53:0] ly_s6 [8];
	logic [40:0] ox_s7 [8];
	logic [40:0] oy_s7 [8];
	logic [41:0] xhh_s8 [8];
	logic [40:0] xhl_s8 [8];
	logic [39:0] xll_s8 [8];
	logic [41:0] yhh_s8 [8];
	logic [40:0] yhl_s8 [8];
	logic [39:0] yll_s8 [8];
	logic [SQ_W-1:0] d_s9 [8];
	logic [SQ_W-1:0] m_s10 [4];
	logic [SQ_W-1:0] m_s11 [2];
	logic [SQ_W-1:0] m_s12;

	logic signed [46:0] p_c [2];
	logic signed [46:0] q_c [2];
	logic signed [46:0] r_c [2];
	logic signed [46:0] t_c [2];
	logic signed [48:0] rawx_c [8];
	logic signed [48:0] rawy_c [8];
	logic signed [35:0] wx_c [8];
	logic signed [35:0] wy_c [8];
	logic signed [36:0] rx_c [8];
	logic signed [36:0] ry_c [8];
	logic signed [53:0] lx_c [8];
	logic signed [53:0] ly_c [8];
	logic [40:0] ox_c [8];
	logic [40:0] oy_c [8];
	logic [SQ_W-1:0] d_c [8];

	tag_t            sq_tag;
	tag_t            res_tag;
	logic            res_vld;
	logic [ROOT_W-1:0] res_root;

	function automatic logic signed [35:0] round14s(input logic signed [48:0] v);
		logic [48:0] m, mr;
		logic [35:0] r;
		m  = v[48] ? 49'(-v) : 49'(v);
		mr = m + 49'd8192;
		r  = {1'b0, mr[48:14]};
		return v[48] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic [40:0] clamp_off(input logic signed [53:0] l,
		input logic [30:0] h);
		logic signed [54:0] lv, hv;
		logic [54:0]        ex, exr;
		lv = 55'(l);
		hv = $signed({10'b0, h, 14'b0});
		if (lv > hv) begin
			ex = 55'(lv - hv);
		end else if (lv < -hv) begin
			ex = 55'(-hv - lv);
		end else begin
			ex = '0;
		end
		exr = ex + 55'd8192;
		return exr[54:14];
	endfunction

	// per box: half extents times heading
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			box_t bx;
			bx = (k == 0) ? j_s1.a : j_s1.b;
			p_c[k] = 47'($signed({1'b0, bx.hx})) * 47'($signed(bx.c));
			q_c[k] = 47'($signed({1'b0, bx.hy})) * 47'($signed(bx.s));
			r_c[k] = 47'($signed({1'b0, bx.hx})) * 47'($signed(bx.s));
			t_c[k] = 47'($signed({1'b0, bx.hy})) * 47'($signed(bx.c));
		end
	end

	// corners at scale 2^14
	always_comb begin
		for (int n = 0; n < 8; n++) begin
			box_t bx;
			logic signed [48:0] px, qy, rx, ty;
			bx = (n >= 4) ? j_s2.b : j_s2.a;
			px = KX_POS[n % 4] ? 49'(p_s2[n / 4]) : -49'(p_s2[n / 4]);
			rx = KX_POS[n % 4] ? 49'(r_s2[n / 4]) : -49'(r_s2[n / 4]);
			qy = KY_POS[n % 4] ? 49'(q_s2[n / 4]) : -49'(q_s2[n / 4]);
			ty = KY_POS[n % 4] ? 49'(t_s2[n / 4]) : -49'(t_s2[n / 4]);
			rawx_c[n] = $signed({{3{bx.cx[31]}}, bx.cx, 14'b0}) + px - qy;
			rawy_c[n] = $signed({{3{bx.cy[31]}}, bx.cy, 14'b0}) + rx + ty;
		end
	end

	always_comb begin
		for (int n = 0; n < 8; n++) begin
			wx_c[n] = round14s(rawx_s3[n]);
			wy_c[n] = round14s(rawy_s3[n]);
		end
	end

	// offset from the other box centre
	always_comb begin
		for (int n = 0; n < 8; n++) begin
			box_t ob;
			ob = (n >= 4) ? j_s4.a : j_s4.b;
			rx_c[n] = 37'(wx_s4[n]) - 37'($signed(ob.cx));
			ry_c[n] = 37'(wy_s4[n]) - 37'($signed(ob.cy));
		end
	end

	// rotate into the other box frame
	always_comb begin
		for (int n = 0; n < 8; n++) begin
			box_t ob;
			ob = (n >= 4) ? j_s5.a : j_s5.b;
			lx_c[n] = 54'(rx_s5[n]) * 54'($signed(ob.c)) + 54'(ry_s5[n]) * 54'($signed(ob.s));
			ly_c[n] = 54'(ry_s5[n]) * 54'($signed(ob.c)) - 54'(rx_s5[n]) * 54'($signed(ob.s));
		end
	end

	always_comb begin
		for (int n = 0; n < 8; n++) begin
			box_t ob;
			ob = (n >= 4) ? j_s6.a : j_s6.b;
			ox_c[n] = clamp_off(lx_s6[n], ob.hx);
			oy_c[n] = clamp_off(ly_s6[n], ob.hy);
		end
	end

	always_comb begin
		for (int n = 0; n < 8; n++) begin
			d_c[n] = (SQ_W'(xhh_s8[n]) << 40) + (SQ_W'(xhl_s8[n]) << 21) + SQ_W'(xll_s8[n])
				+ (SQ_W'(yhh_s8[n]) << 40) + (SQ_W'(yhl_s8[n]) << 21) + SQ_W'(yll_s8[n]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
			ctl_s12 <= '0;
		end else begin
			ctl_s1  <= '{vld: in_vld, ovl: in_job.ovl};
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			ctl_s4  <= ctl_s3;
			ctl_s5  <= ctl_s4;
			ctl_s6  <= ctl_s5;
			ctl_s7  <= ctl_s6;
			ctl_s8  <= ctl_s7;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
			ctl_s11 <= ctl_s10;
			ctl_s12 <= ctl_s11;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= in_job;
		j_s2 <= j_s1;
		j_s3 <= j_s2;
		j_s4 <= j_s3;
		j_s5 <= j_s4;
		j_s6 <= j_s5;
		p_s2 <= p_c;
		q_s2 <= q_c;
		r_s2 <= r_c;
		t_s2 <= t_c;
		rawx_s3 <= rawx_c;
		rawy_s3 <= rawy_c;
		wx_s4 <= wx_c;
		wy_s4 <= wy_c;
		rx_s5 <= rx_c;
		ry_s5 <= ry_c;
		lx_s6 <= lx_c;
		ly_s6 <= ly_c;
		ox_s7 <= ox_c;
		oy_s7 <= oy_c;
		for (int n = 0; n < 8; n++) begin
			xhh_s8[n] <= 42'(ox_s7[n][40:20]) * 42'(ox_s7[n][40:20]);
			xhl_s8[n] <= 41'(ox_s7[n][40:20]) * 41'(ox_s7[n][19:0]);
			xll_s8[n] <= 40'(ox_s7[n][19:0]) * 40'(ox_s7[n][19:0]);
			yhh_s8[n] <= 42'(oy_s7[n][40:20]) * 42'(oy_s7[n][40:20]);
			yhl_s8[n] <= 41'(oy_s7[n][40:20]) * 41'(oy_s7[n][19:0]);
			yll_s8[n] <= 40'(oy_s7[n][19:0]) * 40'(oy_s7[n][19:0]);
		end
		d_s9 <= d_c;
		for (int n = 0; n < 4; n++) begin
			m_s10[n] <= (d_s9[2*n+1] < d_s9[2*n]) ? d_s9[2*n+1] : d_s9[2*n];
		end
		for (int n = 0; n < 2; n++) begin
			m_s11[n] <= (m_s10[2*n+1] < m_s10[2*n]) ? m_s10[2*n+1] : m_s10[2*n];
		end
		m_s12 <= (m_s11[1] < m_s11[0]) ? m_s11[1] : m_s11[0];
	end

	assign sq_tag = '{ovl: ctl_s12.ovl, sat: |m_s12[SQ_W-1:RAD_W]};

	obbcd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (ctl_s12.vld),
		.in_tag   (sq_tag),
		.radicand (m_s12[RAD_W-1:0]),
		.out_vld  (res_vld),
		.out_tag  (res_tag),
		.root     (res_root)
	);

	assign done         = res_vld;
	assign overlapping  = res_tag.ovl;
	assign gap_distance = res_tag.ovl ? '0 : (res_tag.sat ? '1 : res_root);

endmodule
